/* hw/rtl/glbc_pkg.sv */
// Shared types, constants and elaboration-time functions for the geodesic cost pipeline.
package glbc_pkg;

  localparam int COORD_W     = 16;
  localparam int LAYER_W     = 5;
  localparam int RADIUS_W    = 15;
  localparam int DIST_W      = 15;
  localparam int EXP_W       = 16;
  localparam int COST_W      = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_COMP    = 3;
  localparam int NUM_TERMS   = 9;
  localparam int LOG_FRAC    = 24;

  localparam logic [DIST_W-1:0] PI_Q13      = 15'd25736;
  localparam logic [31:0]       PI_Q30      = 32'd3373259426;
  localparam logic [31:0]       HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0]       ONE_Q30     = 32'd1073741824;
  localparam logic [EXP_W-1:0]  EXP_RESET   = 16'd8192;

  typedef struct packed {
    logic [LAYER_W-1:0]  layer_x;
    logic [LAYER_W-1:0]  layer_y;
    logic [RADIUS_W-1:0] radius_x;
    logic [RADIUS_W-1:0] radius_y;
  } side_t;

  typedef struct packed {
    logic [DIST_W-1:0]  lo;
    logic [DIST_W-1:0]  hi;
    logic signed [33:0] d30;
    side_t              side;
  } arc_item_t;

  // divisor of the k-th series term: (2k-1)(2k)
  function automatic int cos_div(input int k);
    return (2 * k - 1) * (2 * k);
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] rem;
    res = '0;
    bt  = 64'd1 << 62;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (bt > rem) bt = bt >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bt != 64'd0) begin
        if (rem >= res + bt) begin
          rem = rem - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // 2^(2^-k) in Q2.30, built by repeated square roots from 2.0
  function automatic logic [31:0] root_coef(input int k);
    logic [63:0] c;
    c = 64'd2147483648;
    for (int i = 1; i <= LOG_FRAC; i++) begin
      if (i <= k) c = isqrt64(c << 30);
    end
    return c[31:0];
  endfunction

endpackage

/* hw/rtl/glbc_arc_step.sv */
// One bisection step of the arc cosine: pipelined cosine series and interval update.
module glbc_arc_step import glbc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  arc_item_t in_item,
  output logic      out_valid,
  output arc_item_t out_item
);

  localparam int NSTG = 3 * NUM_TERMS + 3;

  typedef struct packed {
    logic [DIST_W-1:0]  mid;
    logic               active;
    logic               neg;
    logic [31:0]        t;
    logic [31:0]        t2;
    logic [31:0]        term;
    logic [31:0]        num;
    logic [31:0]        quo;
    logic signed [33:0] sum;
  } cos_t;

  logic      vld [NSTG+1];
  arc_item_t itm [NSTG+1];
  cos_t      cs [NSTG];
  cos_t      cs_next [1:NSTG-1];
  arc_item_t upd_item;

  assign vld[0] = in_valid;
  assign itm[0] = in_item;
  assign cs[0]  = '0;

  generate
    for (genvar i = 1; i <= NSTG; i++) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (en) begin
          vld[i] <= vld[i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          itm[i] <= (i == NSTG) ? upd_item : itm[i-1];
        end
      end
      if (i < NSTG) begin : g_cs
        always_ff @(posedge clk) begin
          if (en) begin
            cs[i] <= cs_next[i];
          end
        end
      end
    end
  endgenerate

  // midpoint, angle and quadrant fold
  always_comb begin
    logic [DIST_W:0] sum_lh;
    logic [31:0]     tr;
    cs_next[1]        = cs[0];
    sum_lh            = {1'b0, itm[0].lo} + {1'b0, itm[0].hi};
    cs_next[1].mid    = sum_lh[DIST_W:1];
    cs_next[1].active = itm[0].lo < itm[0].hi;
    tr                = {sum_lh[DIST_W:1], 17'd0};
    if (tr > PI_Q30) tr = PI_Q30;
    cs_next[1].neg    = tr > HALF_PI_Q30;
    cs_next[1].t      = (tr > HALF_PI_Q30) ? PI_Q30 - tr : tr;
  end

  always_comb begin
    logic [63:0] sq;
    sq              = 64'(cs[1].t) * 64'(cs[1].t);
    cs_next[2]      = cs[1];
    cs_next[2].t2   = sq[61:30];
    cs_next[2].term = ONE_Q30;
    cs_next[2].sum  = 34'sd1073741824;
  end

  generate
    for (genvar k = 1; k <= NUM_TERMS; k++) begin : g_term
      localparam int IA = 3 * k;
      localparam int DV = cos_div(k);
      localparam int LW = $clog2(DV);
      localparam int SH = 32 + LW;
      localparam logic [32:0] RECIP = 33'((65'd1 << SH) / DV);

      always_comb begin
        logic [63:0] p;
        p                = 64'(cs[IA-1].term) * 64'(cs[IA-1].t2);
        cs_next[IA]      = cs[IA-1];
        cs_next[IA].num  = p[61:30];
      end

      // quotient estimate, low by at most one
      always_comb begin
        logic [64:0] pq;
        pq                 = 65'(cs[IA].num) * 65'(RECIP);
        cs_next[IA+1]      = cs[IA];
        cs_next[IA+1].quo  = 32'(pq >> SH);
      end

      always_comb begin
        logic [40:0] qd;
        logic [40:0] rem;
        logic [31:0] tm;
        qd                 = 41'(cs[IA+1].quo) * 41'(DV);
        rem                = 41'(cs[IA+1].num) - qd;
        tm                 = cs[IA+1].quo + 32'(rem >= 41'(DV));
        cs_next[IA+2]      = cs[IA+1];
        cs_next[IA+2].term = tm;
        if (k % 2 == 1) begin
          cs_next[IA+2].sum = cs[IA+1].sum - $signed({2'b00, tm});
        end else begin
          cs_next[IA+2].sum = cs[IA+1].sum + $signed({2'b00, tm});
        end
      end
    end
  endgenerate

  always_comb begin
    logic signed [33:0] cosv;
    cosv     = cs[NSTG-1].neg ? -cs[NSTG-1].sum : cs[NSTG-1].sum;
    upd_item = itm[NSTG-1];
    if (cs[NSTG-1].active) begin
      if (cosv <= $signed(itm[NSTG-1].d30)) begin
        upd_item.hi = cs[NSTG-1].mid;
      end else begin
        upd_item.lo = cs[NSTG-1].mid + 15'd1;
      end
    end
  end

  assign out_valid = vld[NSTG];
  assign out_item  = itm[NSTG];

endmodule

/* hw/rtl/geodesic_lower_bound_cost.sv */
// Top level: geodesic distance between two sphere points, radius bound, power cost.
// The cost passes through 505 register stages after the input transfer.
// Throughput: one transfer per cycle; all stages advance together unless the
// output holds a result under stall. The arc cosine sets the depth: 15 bisection
// steps of 30 stages each, one cosine series evaluation per step.
// Reset clears all valid bits; exponent returns to 2.0 and bottom_layer to 0.
module geodesic_lower_bound_cost import glbc_pkg::*; #(
  parameter int DIM = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [COORD_W-1:0]  x_coord_0,
  input  logic signed [COORD_W-1:0]  x_coord_1,
  input  logic signed [COORD_W-1:0]  x_coord_2,
  input  logic signed [COORD_W-1:0]  y_coord_0,
  input  logic signed [COORD_W-1:0]  y_coord_1,
  input  logic signed [COORD_W-1:0]  y_coord_2,
  input  logic [LAYER_W-1:0]         layer_x,
  input  logic [LAYER_W-1:0]         layer_y,
  input  logic [RADIUS_W-1:0]        radius_x,
  input  logic [RADIUS_W-1:0]        radius_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [COST_W-1:0]          cost
);

  localparam int NUM_STEPS = $clog2(int'(PI_Q13) + 1);
  localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM_LAYER = 2'd1;

  typedef struct packed {
    logic [3:0] b;
    logic       pzero;
    logic       rzero;
  } lg_ctl_t;

  typedef struct packed {
    logic [9:0]  n;
    logic [23:0] f;
    logic        sat;
    logic        pzero;
    logic        rzero;
  } pw_ctl_t;

  logic               en;
  logic [EXP_W-1:0]   exponent;
  logic [LAYER_W-1:0] bottom_layer;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent     <= EXP_RESET;
      bottom_layer <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EXPONENT:     exponent     <= cfg_data;
        REG_BOTTOM_LAYER: bottom_layer <= cfg_data[LAYER_W-1:0];
        default: ;
      endcase
    end
  end

  // dot product
  logic signed [COORD_W-1:0] xc [NUM_COMP];
  logic signed [COORD_W-1:0] yc [NUM_COMP];
  logic signed [31:0]        d1_prod [NUM_COMP];
  logic                      d1_vld;
  side_t                     d1_side;

  assign xc[0] = x_coord_0;
  assign xc[1] = x_coord_1;
  assign xc[2] = x_coord_2;
  assign yc[0] = y_coord_0;
  assign yc[1] = y_coord_1;
  assign yc[2] = y_coord_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_vld <= 1'b0;
    end else if (en) begin
      d1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_side <= '{layer_x: layer_x, layer_y: layer_y, radius_x: radius_x, radius_y: radius_y};
    end
  end

  generate
    for (genvar i = 0; i < NUM_COMP; i++) begin : g_prod
      always_ff @(posedge clk) begin
        if (en) begin
          if (i < DIM) begin
            d1_prod[i] <= xc[i] * yc[i];
          end else begin
            d1_prod[i] <= '0;
          end
        end
      end
    end
  endgenerate

  logic      arc_vld  [NUM_STEPS+1];
  arc_item_t arc_item [NUM_STEPS+1];
  arc_item_t arc_first;

  always_comb begin
    logic signed [33:0] dot;
    dot = '0;
    for (int i = 0; i < NUM_COMP; i++) dot = dot + 34'(d1_prod[i]);
    arc_first.side = d1_side;
    arc_first.d30  = {dot[31:0], 2'b00};
    if (dot >= 34'sd268435456) begin
      arc_first.lo = '0;
      arc_first.hi = '0;
    end else if (dot <= -34'sd268435456) begin
      arc_first.lo = PI_Q13;
      arc_first.hi = PI_Q13;
    end else begin
      arc_first.lo = '0;
      arc_first.hi = PI_Q13;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arc_vld[0] <= 1'b0;
    end else if (en) begin
      arc_vld[0] <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arc_item[0] <= arc_first;
    end
  end

  generate
    for (genvar s = 0; s < NUM_STEPS; s++) begin : g_step
      glbc_arc_step u_step (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .in_valid  (arc_vld[s]),
        .in_item   (arc_item[s]),
        .out_valid (arc_vld[s+1]),
        .out_item  (arc_item[s+1])
      );
    end
  endgenerate

  // radius bound
  logic              r_vld;
  logic [DIST_W-1:0] r_dist;
  logic [DIST_W-1:0] r_dist_next;

  always_comb begin : radius_calc
    logic signed [DIST_W+2:0] dsum;
    side_t sd;
    sd   = arc_item[NUM_STEPS].side;
    dsum = $signed({3'b000, arc_item[NUM_STEPS].lo});
    if (sd.layer_x < bottom_layer) dsum = dsum - $signed({3'b000, sd.radius_x});
    if (sd.layer_y < bottom_layer) dsum = dsum - $signed({3'b000, sd.radius_y});
    r_dist_next = (dsum < 0) ? '0 : dsum[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else if (en) begin
      r_vld <= arc_vld[NUM_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_dist <= r_dist_next;
    end
  end

  // log2 by normalize and square
  logic    lg_vld  [LOG_FRAC+1];
  logic [30:0] lg_m [LOG_FRAC+1];
  logic [23:0] lg_frac [LOG_FRAC+1];
  lg_ctl_t lg_ctl  [LOG_FRAC+1];
  logic [3:0]  r_msb;

  always_comb begin
    r_msb = '0;
    for (int i = 0; i < DIST_W; i++) begin
      if (r_dist[i]) r_msb = 4'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lg_vld[0] <= 1'b0;
    end else if (en) begin
      lg_vld[0] <= r_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lg_m[0]    <= 31'({16'd0, r_dist} << (5'd30 - {1'b0, r_msb}));
      lg_frac[0] <= '0;
      lg_ctl[0]  <= '{b: r_msb, pzero: exponent == '0, rzero: r_dist == '0};
    end
  end

  generate
    for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_log
      logic [61:0] sq;
      logic [31:0] mm;
      assign sq = 62'(lg_m[k-1]) * 62'(lg_m[k-1]);
      assign mm = sq[61:30];

      always_ff @(posedge clk) begin
        if (rst) begin
          lg_vld[k] <= 1'b0;
        end else if (en) begin
          lg_vld[k] <= lg_vld[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          lg_m[k]    <= mm[31] ? mm[31:1] : mm[30:0];
          lg_frac[k] <= {lg_frac[k-1][22:0], mm[31]};
          lg_ctl[k]  <= lg_ctl[k-1];
        end
      end
    end
  endgenerate

  // scale by exponent
  logic               p1_vld;
  logic signed [45:0] p1_prod;
  lg_ctl_t            p1_ctl;
  logic signed [4:0]  bm13;
  logic signed [28:0] lgv;

  assign bm13 = $signed({1'b0, lg_ctl[LOG_FRAC].b}) - 5'sd13;
  assign lgv  = $signed({bm13, lg_frac[LOG_FRAC]});

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= lg_vld[LOG_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_prod <= 46'(lgv) * 46'($signed({1'b0, exponent}));
      p1_ctl  <= lg_ctl[LOG_FRAC];
    end
  end

  logic               g_vld [LOG_FRAC+1];
  logic [31:0]        g_val [LOG_FRAC+1];
  pw_ctl_t            g_ctl [LOG_FRAC+1];
  logic signed [33:0] e_val;

  assign e_val = 34'(p1_prod >>> 12);

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld[0] <= 1'b0;
    end else if (en) begin
      g_vld[0] <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_val[0] <= ONE_Q30;
      g_ctl[0] <= '{n: e_val[33:24], f: e_val[23:0], sat: e_val >= 34'sd268435456,
                    pzero: p1_ctl.pzero, rzero: p1_ctl.rzero};
    end
  end

  // 2^frac as a product of root coefficients
  generate
    for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_exp
      localparam logic [31:0] COEF = root_coef(k);
      logic [63:0] gp;
      assign gp = 64'(g_val[k-1]) * 64'(COEF);

      always_ff @(posedge clk) begin
        if (rst) begin
          g_vld[k] <= 1'b0;
        end else if (en) begin
          g_vld[k] <= g_vld[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          g_val[k] <= g_ctl[k-1].f[LOG_FRAC-k] ? gp[61:30] : g_val[k-1];
          g_ctl[k] <= g_ctl[k-1];
        end
      end
    end
  endgenerate

  // final scaling, rounding, saturation and zero-exponent and zero-distance cases
  logic [COST_W-1:0] cost_next;

  always_comb begin
    logic signed [10:0] sh;
    logic signed [10:0] s;
    logic [63:0]        o64;
    pw_ctl_t            c;
    c  = g_ctl[LOG_FRAC];
    sh = $signed({c.n[9], c.n}) - 11'sd14;
    s  = -sh;
    if (!sh[10]) begin
      o64 = 64'(g_val[LOG_FRAC]) << sh[0];
    end else if (s >= 11'sd63) begin
      o64 = '0;
    end else begin
      o64 = (64'(g_val[LOG_FRAC]) + (64'd1 << (s[5:0] - 6'd1))) >> s[5:0];
    end
    if (c.pzero) begin
      cost_next = 32'd65536;
    end else if (c.rzero) begin
      cost_next = '0;
    end else if (c.sat || o64 > 64'h0000_0000_FFFF_FFFF) begin
      cost_next = '1;
    end else begin
      cost_next = o64[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= g_vld[LOG_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cost <= cost_next;
    end
  end

endmodule

/* hw/rtl/glbc_checker.sv */
// Port-level checks for the geodesic cost block, bound to the top level.
module glbc_checker import glbc_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [CFG_INDEX_W-1:0]    cfg_index,
  input logic [CFG_DATA_W-1:0]     cfg_data,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic signed [COORD_W-1:0] x_coord_0,
  input logic signed [COORD_W-1:0] x_coord_1,
  input logic signed [COORD_W-1:0] x_coord_2,
  input logic signed [COORD_W-1:0] y_coord_0,
  input logic signed [COORD_W-1:0] y_coord_1,
  input logic signed [COORD_W-1:0] y_coord_2,
  input logic [LAYER_W-1:0]        layer_x,
  input logic [LAYER_W-1:0]        layer_y,
  input logic [RADIUS_W-1:0]       radius_x,
  input logic [RADIUS_W-1:0]       radius_y,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [COST_W-1:0]         cost
);

  // input side only backs up when a finished result is held
  a_stall_src: assert property (@(posedge clk) in_stall == (out_valid && out_stall))
    else $error("input stall without a held result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(cost)))
    else $error("stalled result changed or dropped");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind geodesic_lower_bound_cost glbc_checker u_glbc_checker (.*);
